/* sv/bprx_pkg.sv */
// shared constants, types and checksum function of the biphase frame receiver
`default_nettype none

package bprx_pkg;

  localparam int SYNC_BITS      = 32;
  localparam int FRAME_LEN      = 121;
  localparam int CHECK_POS      = 99;
  localparam int MAX_AUX        = 20;
  localparam int STD_LEN        = CHECK_POS + 1;
  localparam int FRAME_RAW_BITS = FRAME_LEN * 16;
  localparam int RAW_POS_W      = $clog2(FRAME_RAW_BITS);
  localparam int FILL_W         = $clog2(SYNC_BITS + 1);
  localparam int AUX_W          = 5;
  localparam int INDEX_W        = 7;
  localparam int MID_DEPTH      = 4;
  localparam int MID_PTR_W      = $clog2(MID_DEPTH);

  localparam logic [31:0] SYNC_RESET = 32'h9999_4C99;

  typedef struct packed {
    logic [7:0]         value;
    logic [INDEX_W-1:0] index;
  } byte_evt_t;

  function automatic logic [15:0] cks_update(input logic [15:0] c, input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] br;
    logic [7:0] t;
    logic [7:0] s;
    logic       t6;
    logic       t7;
    hi = c[7:0];
    br = {b[0], b[7:1]};
    br = br ^ (br >> 2);
    t6 = c[0] ^ c[2] ^ c[4];
    t7 = c[1] ^ c[3] ^ c[5];
    t  = {t7, t6, c[5:0]};
    s  = c[14:7];
    s  = s ^ (s >> 2);
    return {hi, br ^ t ^ s};
  endfunction

endpackage

`default_nettype wire

/* sv/bprx_front.sv */
// front end: sync hunt, biphase pair decode and byte assembly
`default_nettype none

module bprx_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic               raw_bit,
  input  wire logic               cfg_valid,
  input  wire logic [31:0]        sync_pattern,
  output logic                    evt_push,
  output bprx_pkg::byte_evt_t     evt
);
  import bprx_pkg::*;

  logic [31:0]          pattern;
  logic [SYNC_BITS-1:0] window;
  logic [SYNC_BITS-1:0] window_next;
  logic [SYNC_BITS-1:0] pat_w;
  logic [FILL_W-1:0]    fill;
  logic [FILL_W-1:0]    fill_next;
  logic                 locked;
  logic [RAW_POS_W-1:0] pos;
  logic                 pair_first;
  logic                 prev;
  logic [6:0]           byte_shift;
  logic                 sync_hit;
  logic                 pair_valid;
  logic                 data;
  logic                 prev_after;
  logic                 byte_done;
  logic                 pos_last;

  always_comb begin
    window_next = {window[SYNC_BITS-2:0], raw_bit};
    pat_w       = SYNC_BITS'(pattern);
    fill_next   = (fill == FILL_W'(SYNC_BITS)) ? fill : fill + 1'b1;
    sync_hit    = (fill_next == FILL_W'(SYNC_BITS)) &&
                  ((window_next == pat_w) || (window_next == ~pat_w));
    pair_valid  = pair_first ^ raw_bit;
    data        = pair_valid && (prev == pair_first);
    prev_after  = pair_valid ? pair_first : 1'b0;
    byte_done   = pos[0] && (pos[3:1] == 3'b111);
    pos_last    = (pos == RAW_POS_W'(FRAME_RAW_BITS - 1));
    evt_push    = accept && locked && byte_done;
    evt.value   = {byte_shift, data};
    evt.index   = INDEX_W'(pos >> 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern    <= SYNC_RESET;
      window     <= '0;
      fill       <= '0;
      locked     <= 1'b0;
      pos        <= '0;
      pair_first <= 1'b0;
      prev       <= 1'b0;
      byte_shift <= '0;
    end else begin
      if (cfg_valid) begin
        pattern <= sync_pattern;
      end
      if (accept) begin
        window <= window_next;
        if (!locked) begin
          fill <= fill_next;
          if (sync_hit) begin
            locked     <= 1'b1;
            pos        <= '0;
            byte_shift <= '0;
          end
        end else begin
          if (!pos[0]) begin
            pair_first <= raw_bit;
            if (pos == '0) begin
              prev <= ~raw_bit;
            end
          end else begin
            prev       <= prev_after;
            byte_shift <= byte_done ? 7'd0 : {byte_shift[5:0], data};
          end
          if (pos_last) begin
            pos    <= '0;
            locked <= 1'b0;
          end else begin
            pos <= pos + 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/bprx_fifo.sv */
// short queue of decoded bytes between front and back
`default_nettype none

module bprx_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire bprx_pkg::byte_evt_t push_data,
  output logic                     full,
  input  wire logic                pop,
  output bprx_pkg::byte_evt_t      pop_data,
  output logic                     empty
);
  import bprx_pkg::*;

  byte_evt_t            mem [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr;
  logic [MID_PTR_W-1:0] rd_ptr;
  logic [MID_PTR_W:0]   count;
  logic                 do_push;
  logic                 do_pop;

  always_comb begin
    full     = (count == (MID_PTR_W+1)'(MID_DEPTH));
    empty    = (count == '0);
    do_push  = push && !full;
    do_pop   = pop && !empty;
    pop_data = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/bprx_back.sv */
// back end: aux length, checksum, frame end and result register
`default_nettype none

module bprx_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                evt_empty,
  input  wire bprx_pkg::byte_evt_t evt,
  output logic                     evt_pop,
  input  wire logic                pop,
  output logic                     empty,
  output logic [7:0]               byte_value,
  output logic [6:0]               byte_index,
  output logic                     last_byte,
  output logic                     checksum_match
);
  import bprx_pkg::*;

  logic [15:0]      cks;
  logic [7:0]       recv_high;
  logic [AUX_W-1:0] aux;
  logic             check_ok;
  logic             out_valid;

  logic             first;
  logic [15:0]      cks_base;
  logic [15:0]      cks_next;
  logic [7:0]       high_base;
  logic [7:0]       recv_high_next;
  logic             ok_base;
  logic             check_ok_next;
  logic [AUX_W-1:0] aux_next;
  logic [7:0]       aux_diff;
  logic [7:0]       last_idx;
  logic [7:0]       idx8;
  logic             emit;
  logic             is_last;

  always_comb begin
    first     = (evt.index == '0);
    cks_base  = first ? 16'd0 : cks;
    high_base = first ? 8'd0 : recv_high;
    ok_base   = first ? 1'b0 : check_ok;
    aux_diff  = evt.value - 8'(STD_LEN);
    if (first) begin
      if ((evt.value > 8'(STD_LEN)) && (aux_diff <= 8'(MAX_AUX))) begin
        aux_next = AUX_W'(aux_diff);
      end else begin
        aux_next = '0;
      end
    end else begin
      aux_next = aux;
    end
    cks_next       = (evt.index < INDEX_W'(CHECK_POS)) ? cks_update(cks_base, evt.value)
                                                       : cks_base;
    recv_high_next = (evt.index == INDEX_W'(CHECK_POS)) ? evt.value : high_base;
    check_ok_next  = (evt.index == INDEX_W'(CHECK_POS + 1)) ?
                     ({high_base, evt.value} == cks_base) : ok_base;
    last_idx = 8'(STD_LEN) + {{(8-AUX_W){1'b0}}, aux_next};
    if (last_idx > 8'(FRAME_LEN - 1)) begin
      last_idx = 8'(FRAME_LEN - 1);
    end
    idx8    = {1'b0, evt.index};
    emit    = (idx8 <= last_idx);
    is_last = (idx8 == last_idx);
    evt_pop = !evt_empty && (!out_valid || pop);
    empty   = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cks       <= '0;
      recv_high <= '0;
      aux       <= '0;
      check_ok  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !pop) || (evt_pop && emit);
      if (evt_pop) begin
        cks       <= cks_next;
        recv_high <= recv_high_next;
        aux       <= aux_next;
        check_ok  <= check_ok_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_pop && emit) begin
      byte_value     <= evt.value;
      byte_index     <= evt.index;
      last_byte      <= is_last;
      checksum_match <= is_last && (idx8 >= 8'(STD_LEN)) && check_ok_next;
    end
  end

endmodule

`default_nettype wire

/* sv/biphase_frame_receiver_with_checksum_core.sv */
// top level of the biphase frame receiver with sync word and checksum
//
//   channel   handshake              payload
//   input     push / full            raw_bit
//   result    empty / pop            byte_value, byte_index, last_byte, checksum_match
//   config    cfg_valid / cfg_ready  sync_pattern
//
// one raw bit is taken per cycle unless full is high; the front decodes it that cycle
// a byte result passes through the byte queue and then the result register
// full rises only when the 4-entry byte queue fills while results are not popped
// reset restores the sync word 0x99994C99
`default_nettype none

module biphase_frame_receiver_with_checksum_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        raw_bit,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       byte_value,
  output logic [6:0]       byte_index,
  output logic             last_byte,
  output logic             checksum_match,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] sync_pattern
);
  import bprx_pkg::*;

  logic      accept;
  logic      evt_push;
  byte_evt_t evt_in;
  byte_evt_t evt_out;
  logic      mid_full;
  logic      mid_empty;
  logic      evt_pop;

  assign accept    = push && !mid_full;
  assign full      = mid_full;
  assign cfg_ready = 1'b1;

  bprx_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .raw_bit      (raw_bit),
    .cfg_valid    (cfg_valid),
    .sync_pattern (sync_pattern),
    .evt_push     (evt_push),
    .evt          (evt_in)
  );

  bprx_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (evt_push),
    .push_data (evt_in),
    .full      (mid_full),
    .pop       (evt_pop),
    .pop_data  (evt_out),
    .empty     (mid_empty)
  );

  bprx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .evt_empty      (mid_empty),
    .evt            (evt_out),
    .evt_pop        (evt_pop),
    .pop            (pop),
    .empty          (empty),
    .byte_value     (byte_value),
    .byte_index     (byte_index),
    .last_byte      (last_byte),
    .checksum_match (checksum_match)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    evt_push |-> !mid_full)
    else $error("byte queue overflow");

  a_match_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && checksum_match) |-> last_byte)
    else $error("checksum match without last byte");

  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (byte_index <= 7'(FRAME_LEN - 1)))
    else $error("byte index beyond frame");

  a_drain_when_free: assert property (@(posedge clk) disable iff (rst)
    (empty && !mid_empty) |-> evt_pop)
    else $error("queued byte not taken while result register free");

endmodule

`default_nettype wire
